### hw/rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int CAP_W     = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take_in;
    logic exec;
    logic rd;
    logic load;
  } cmd_t;

endpackage

### hw/rtl/bdq_if.sv
`timescale 1ns / 1ps

interface bdq_in_if;
  logic                              valid;
  logic                              ready;
  logic [bdq_pkg::OP_W-1:0]          opcode;
  logic signed [bdq_pkg::DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface bdq_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic signed [bdq_pkg::DATA_W-1:0] front_value;
  logic signed [bdq_pkg::DATA_W-1:0] rear_value;
  logic                              is_empty;
  logic                              is_full;

  modport source (output valid, output accepted, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input accepted, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

### hw/rtl/bounded_double_ended_queue_top.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values held in a ring memory.
// in_i carries an opcode (push front, push rear, pop front, pop rear, peek)
// and a value; every transfer on in_i yields exactly one transfer on out_o
// with the accepted flag, front and rear values (-1 when empty) and the
// empty and full flags, all as seen after the operation.
// cfg_we_i/cfg_wdata_i write the capacity register; write it only while the
// block is idle. Capacities above DEPTH act as DEPTH.
// One item is in flight at a time: a new input is taken only once the last one
// has passed through its steps of capture, state update with memory write,
// memory read of front and rear, and result load; out_o.valid rises with the
// result load. The memory's registered read port puts the read after the write.
// The result sits in an output register, so a stalled out_o does not stop
// the next input transfer; it holds the following item in its load step
// until the previous result has been taken.
// Reset clears head and count (queue empty) and sets capacity to 1024.
// The ring memory itself is not cleared; only written entries are read.
module bounded_double_ended_queue_top #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bdq_in_if.sink                           in_i,
  bdq_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [bdq_pkg::CAP_W-1:0]        cfg_wdata_i
);

  bdq_pkg::cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .in_opcode_i       (in_i.opcode),
    .in_value_i        (in_i.value),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_accepted_o    (out_o.accepted),
    .out_front_value_o (out_o.front_value),
    .out_rear_value_o  (out_o.rear_value),
    .out_is_empty_o    (out_o.is_empty),
    .out_is_full_o     (out_o.is_full)
  );

endmodule

### hw/rtl/bdq_ctrl.sv
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bdq_pkg::cmd_t cmd_o
);

  bdq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      bdq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = bdq_pkg::ST_EXEC;
        end
      end
      bdq_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = bdq_pkg::ST_READ;
      end
      bdq_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = bdq_pkg::ST_LOAD;
      end
      bdq_pkg::ST_LOAD: begin
        // wait here while the previous result is still stalled
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = bdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/bdq_datapath.sv
`timescale 1ns / 1ps

module bdq_datapath #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bdq_pkg::cmd_t                     cmd_i,
  input  logic [bdq_pkg::OP_W-1:0]          in_opcode_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_value_i,
  input  logic                              cfg_we_i,
  input  logic [bdq_pkg::CAP_W-1:0]         cfg_wdata_i,
  output logic                              out_accepted_o,
  output logic signed [bdq_pkg::DATA_W-1:0] out_front_value_o,
  output logic signed [bdq_pkg::DATA_W-1:0] out_rear_value_o,
  output logic                              out_is_empty_o,
  output logic                              out_is_full_o
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;
  localparam logic [AW-1:0]   LAST_IDX = AW'(DEPTH - 1);
  localparam logic [SW-1:0]   DEPTH_S  = SW'(DEPTH);
  localparam logic [CMPW-1:0] DEPTH_C  = CMPW'(DEPTH);

  logic [bdq_pkg::DATA_W-1:0] ring_q [DEPTH];
  logic [bdq_pkg::DATA_W-1:0] front_rd_q, rear_rd_q;

  bdq_pkg::op_e               op_q;
  logic [bdq_pkg::DATA_W-1:0] val_q;
  logic [bdq_pkg::CAP_W-1:0]  cap_q;
  logic [AW-1:0]              head_q, head_d;
  logic [CW-1:0]              count_q, count_d;
  logic                       ok_q, ok_d;

  logic                       out_ok_q, out_empty_q, out_full_q;
  logic [bdq_pkg::DATA_W-1:0] out_front_q, out_rear_q;

  logic [CMPW-1:0] cap_x, cap_eff;
  logic            full, empty;
  logic [AW-1:0]   head_dec, head_inc, tail_addr, rear_addr, wr_addr;
  logic [SW-1:0]   sum, sum_m1;
  logic            wr_en;

  assign cap_x   = CMPW'(cap_q);
  assign cap_eff = (cap_x > DEPTH_C) ? DEPTH_C : cap_x;
  assign full    = CMPW'(count_q) >= cap_eff;
  assign empty   = (count_q == '0);

  assign head_dec  = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign head_inc  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign sum       = SW'(head_q) + SW'(count_q);
  assign sum_m1    = sum - 1'b1;
  assign tail_addr = (sum >= DEPTH_S) ? AW'(sum - DEPTH_S) : AW'(sum);
  assign rear_addr = (sum_m1 >= DEPTH_S) ? AW'(sum_m1 - DEPTH_S) : AW'(sum_m1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    ok_d    = 1'b0;
    wr_en   = 1'b0;
    wr_addr = tail_addr;
    unique case (op_q)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (!full) begin
          head_d  = head_dec;
          wr_addr = head_dec;
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
        end
      end
      bdq_pkg::OP_PUSH_REAR: begin
        if (!full) begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (!empty) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
        end
      end
      bdq_pkg::OP_POP_REAR: begin
        if (!empty) begin
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
        end
      end
      bdq_pkg::OP_PEEK: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      cap_q   <= bdq_pkg::CAP_RESET;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      op_q  <= bdq_pkg::op_e'(in_opcode_i);
      val_q <= in_value_i;
    end
    if (cmd_i.exec) begin
      ok_q <= ok_d;
    end
    if (cmd_i.load) begin
      out_ok_q    <= ok_q;
      out_empty_q <= empty;
      out_full_q  <= full;
      out_front_q <= empty ? '1 : front_rd_q;
      out_rear_q  <= empty ? '1 : rear_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      ring_q[wr_addr] <= val_q;
    end
    if (cmd_i.rd) begin
      front_rd_q <= ring_q[head_q];
      rear_rd_q  <= ring_q[rear_addr];
    end
  end

  assign out_accepted_o    = out_ok_q;
  assign out_front_value_o = out_front_q;
  assign out_rear_value_o  = out_rear_q;
  assign out_is_empty_o    = out_empty_q;
  assign out_is_full_o     = out_full_q;

endmodule

### sim/bounded_double_ended_queue_top_tb.sv
`timescale 1ns / 1ps

module bounded_double_ended_queue_top_tb;
  import bdq_pkg::*;

  localparam int          RING_DEPTH  = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 8;

  localparam logic [OP_W-1:0]   OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0]   OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0]   OP_SPARE_7 = 3'd7;
  localparam logic [DATA_W-1:0] NEG_ONE    = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] MAX_POS    = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MIN_NEG    = 32'h8000_0000;

  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] rear_value;
    logic              is_empty;
    logic              is_full;
  } deque_result_t;

  typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] val;
    logic              typed;
    deque_result_t     res;
  } dir_row_t;

  typedef struct packed {
    logic          typed;
    deque_result_t res;
  } row_tag_t;

  typedef struct packed {
    logic [CAP_W-1:0] cap;
    logic [15:0]      n_items;
    logic [7:0]       push_pct;
  } phase_t;

  localparam deque_result_t NO_RES = '0;
  localparam int N_ROWS = 26;
  localparam int N_PHASES = 8;

  dir_row_t dir_rows [N_ROWS] = '{
    '{ROW_ITEM, OP_PEEK,       32'h0,      1'b1, '{1'b1, NEG_ONE, NEG_ONE, 1'b1, 1'b0}},
    '{ROW_ITEM, OP_POP_FRONT,  32'h0,      1'b1, '{1'b0, NEG_ONE, NEG_ONE, 1'b1, 1'b0}},
    '{ROW_ITEM, OP_POP_REAR,   32'h0,      1'b1, '{1'b0, NEG_ONE, NEG_ONE, 1'b1, 1'b0}},
    '{ROW_ITEM, OP_SPARE_5,    MAX_POS,    1'b1, '{1'b0, NEG_ONE, NEG_ONE, 1'b1, 1'b0}},
    '{ROW_ITEM, OP_PUSH_FRONT, MAX_POS,    1'b1, '{1'b1, MAX_POS, MAX_POS, 1'b0, 1'b0}},
    '{ROW_ITEM, OP_PUSH_REAR,  MIN_NEG,    1'b1, '{1'b1, MAX_POS, MIN_NEG, 1'b0, 1'b0}},
    '{ROW_ITEM, OP_PUSH_FRONT, 32'h0,      1'b1, '{1'b1, 32'h0,   MIN_NEG, 1'b0, 1'b0}},
    '{ROW_ITEM, OP_PUSH_REAR,  NEG_ONE,    1'b1, '{1'b1, 32'h0,   NEG_ONE, 1'b0, 1'b0}},
    '{ROW_ITEM, OP_SPARE_6,    32'h1234,   1'b1, '{1'b0, 32'h0,   NEG_ONE, 1'b0, 1'b0}},
    '{ROW_ITEM, OP_SPARE_7,    MIN_NEG,    1'b1, '{1'b0, 32'h0,   NEG_ONE, 1'b0, 1'b0}},
    '{ROW_CAP,  OP_PEEK,       32'd2,      1'b0, NO_RES},
    '{ROW_ITEM, OP_PUSH_REAR,  32'h1,      1'b1, '{1'b0, 32'h0,   NEG_ONE, 1'b0, 1'b1}},
    '{ROW_ITEM, OP_POP_REAR,   32'h0,      1'b1, '{1'b1, 32'h0,   MIN_NEG, 1'b0, 1'b1}},
    '{ROW_ITEM, OP_POP_FRONT,  32'h0,      1'b1, '{1'b1, MAX_POS, MIN_NEG, 1'b0, 1'b1}},
    '{ROW_ITEM, OP_POP_FRONT,  32'h0,      1'b1, '{1'b1, MIN_NEG, MIN_NEG, 1'b0, 1'b0}},
    '{ROW_CAP,  OP_PEEK,       32'd0,      1'b0, NO_RES},
    '{ROW_ITEM, OP_PUSH_FRONT, 32'h5,      1'b1, '{1'b0, MIN_NEG, MIN_NEG, 1'b0, 1'b1}},
    '{ROW_ITEM, OP_POP_REAR,   32'h0,      1'b1, '{1'b1, NEG_ONE, NEG_ONE, 1'b1, 1'b1}},
    '{ROW_CAP,  OP_PEEK,       32'd1,      1'b0, NO_RES},
    '{ROW_ITEM, OP_PUSH_FRONT, 32'h5555_5555, 1'b0, NO_RES},
    '{ROW_ITEM, OP_PUSH_REAR,  32'hAAAA_AAAA, 1'b0, NO_RES},
    '{ROW_CAP,  OP_PEEK,       32'd2047,   1'b0, NO_RES},
    '{ROW_ITEM, OP_PUSH_REAR,  32'hAAAA_AAAA, 1'b0, NO_RES},
    '{ROW_ITEM, OP_POP_FRONT,  32'h0,      1'b0, NO_RES},
    '{ROW_ITEM, OP_POP_FRONT,  32'h0,      1'b0, NO_RES},
    '{ROW_ITEM, OP_POP_REAR,   32'h0,      1'b1, '{1'b0, NEG_ONE, NEG_ONE, 1'b1, 1'b0}}
  };

  // last two phases: deep fill with capacity above the ring depth,
  // then capacity dropped far below count
  phase_t phases [N_PHASES] = '{
    '{11'd1,    16'd60,   8'd50},
    '{11'd0,    16'd40,   8'd50},
    '{11'd3,    16'd120,  8'd55},
    '{11'd1024, 16'd100,  8'd55},
    '{11'd12,   16'd100,  8'd55},
    '{11'd2,    16'd80,   8'd50},
    '{11'd2047, 16'd350,  8'd97},
    '{11'd5,    16'd150,  8'd20}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_double_ended_queue_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // deque predictor state
  logic [DATA_W-1:0] ring_mirror [RING_DEPTH];
  int unsigned       head_mirror = 0;
  int unsigned       count_mirror = 0;
  int unsigned       cap_mirror = 32'(CAP_RESET);

  deque_result_t pending_results [$];
  row_tag_t      row_tags [$];

  int unsigned src_idle_pct = 16;
  int unsigned snk_idle_pct = 64;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_refused = 0;
  int unsigned n_full_seen = 0;
  int unsigned n_cap_writes = 0;

  function automatic deque_result_t deque_apply(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
    int unsigned   eff_cap;
    logic          full;
    deque_result_t r;
    eff_cap = (cap_mirror > RING_DEPTH) ? RING_DEPTH : cap_mirror;
    full = count_mirror >= eff_cap;
    r = '0;
    case (op)
      OP_PUSH_FRONT: begin
        if (!full) begin
          head_mirror = (head_mirror + RING_DEPTH - 1) % RING_DEPTH;
          ring_mirror[head_mirror] = val;
          count_mirror++;
          r.accepted = 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        if (!full) begin
          ring_mirror[(head_mirror + count_mirror) % RING_DEPTH] = val;
          count_mirror++;
          r.accepted = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (count_mirror != 0) begin
          head_mirror = (head_mirror + 1) % RING_DEPTH;
          count_mirror--;
          r.accepted = 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (count_mirror != 0) begin
          count_mirror--;
          r.accepted = 1'b1;
        end
      end
      OP_PEEK: r.accepted = 1'b1;
      default: r.accepted = 1'b0;
    endcase
    r.front_value = NEG_ONE;
    r.rear_value  = NEG_ONE;
    if (count_mirror != 0) begin
      r.front_value = ring_mirror[head_mirror];
      r.rear_value  = ring_mirror[(head_mirror + count_mirror - 1) % RING_DEPTH];
    end
    r.is_empty = count_mirror == 0;
    r.is_full  = count_mirror >= eff_cap;
    return r;
  endfunction

  task automatic report_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor_blk
    deque_result_t pred;
    deque_result_t got;
    deque_result_t want;
    row_tag_t      tag;
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("FAILED: results differ");
        $finish;
      end
      if (cfg_we_i) cap_mirror = 32'(cfg_wdata_i);
      if (in_ch.valid && in_ch.ready) begin
        pred = deque_apply(in_ch.opcode, in_ch.value);
        tag = row_tags.pop_front();
        pending_results.push_back(tag.typed ? tag.res : pred);
        n_items++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.accepted, out_ch.front_value, out_ch.rear_value,
                out_ch.is_empty, out_ch.is_full};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, actual %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          n_results++;
          if (!got.accepted) n_refused++;
          if (got.is_full) n_full_seen++;
          report_field("accepted", want.accepted, got.accepted);
          report_field("front_value", want.front_value, got.front_value);
          report_field("rear_value", want.rear_value, got.rear_value);
          report_field("is_empty", want.is_empty, got.is_empty);
          report_field("is_full", want.is_full, got.is_full);
        end
      end
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] val, logic typed,
                           deque_result_t res);
    row_tags.push_back('{typed, res});
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.value  <= val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 || row_tags.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_cap_writes++;
  endtask

  logic [DATA_W-1:0] extreme_vals [4] = '{MAX_POS, MIN_NEG, 32'h0, NEG_ONE};

  initial begin : main_blk
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] val;
    int unsigned       r;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_PEEK;
    in_ch.value    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CAP) set_capacity(dir_rows[i].val[CAP_W-1:0]);
      else send_item(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 3) begin
        src_idle_pct = 16;
        snk_idle_pct = 64;
      end else if (p < 6) begin
        src_idle_pct = 64;
        snk_idle_pct = 16;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      set_capacity(phases[p].cap);
      for (int k = 0; k < phases[p].n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        else if (r < 9) op = OP_PEEK;
        else if ($urandom_range(0, 99) < phases[p].push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        else
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
        val = ($urandom_range(0, 9) == 0) ? extreme_vals[$urandom_range(0, 3)] : $urandom;
        send_item(op, val, 1'b0, NO_RES);
      end
    end

    wait_drained();
    $display("Ran %0d operations over %0d capacity settings (0, 1..12, 1024, 2047).",
             n_items, n_cap_writes);
    $display("Checked %0d results: %0d refused or spare ops, %0d reporting full.",
             n_results, n_refused, n_full_seen);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
